// ===== hdl/cia_pkg.sv =====
// Package for the checked integer ALU: opcodes, payload structs and stage records.
// No dependencies; used by every module of the block except cia_mul.
package cia_pkg;

    localparam int unsigned DivSteps  = 64;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_MUL    = 5'd2,
        CMD_DIV    = 5'd3,
        CMD_MOD    = 5'd4,
        CMD_GT     = 5'd5,
        CMD_LT     = 5'd6,
        CMD_GE     = 5'd7,
        CMD_LE     = 5'd8,
        CMD_EQ     = 5'd9,
        CMD_NE     = 5'd10,
        CMD_NEG    = 5'd11,
        CMD_POS    = 5'd12,
        CMD_AND    = 5'd13,
        CMD_OR     = 5'd14,
        CMD_BOOLEQ = 5'd15,
        CMD_BOOLNE = 5'd16,
        CMD_NOT    = 5'd17
    } cmd_t;

    typedef struct packed {
        logic [4:0]         command;
        logic               a_is_bool;
        logic               b_is_bool;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
        logic               range_valid;
        logic signed [63:0] range_min;
        logic signed [63:0] range_max;
    } in_item_t;

    typedef struct packed {
        logic               result_valid;
        logic               overflow;
        logic               result_is_bool;
        logic signed [63:0] result_value;
    } out_item_t;

    // Decoded result of the front stage, carried along the pipeline.
    typedef struct packed {
        logic        is_mul;
        logic        is_div;
        logic        is_mod;
        logic        neg_q;
        logic        neg_r;
        logic        rv;
        logic [63:0] rmin;
        logic [63:0] rmax;
        logic        valid;
        logic        ovf;
        logic        isbool;
        logic [63:0] val;
    } ctl_t;

    function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// ===== hdl/checked_integer_alu.sv =====
// Top level of the checked integer ALU: front decode, multiplier, divider, finish and output.
// Depends on cia_pkg, cia_front, cia_mul and cia_div.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_data  (cia_pkg::in_item_t)
//   m_      | out       | m_valid / m_ready  | m_data  (cia_pkg::out_item_t)
//
// A transaction is accepted every cycle while the output is not stalled; the
// path runs through the front register, the 64-stage divider and the output
// register, with the finish logic in front of the output register.
// The whole pipeline holds while a result waits with m_ready low.
// aresetn clears the valid bits only.
module checked_integer_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cia_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cia_pkg::out_item_t   m_data
);
    localparam int unsigned Depth = cia_pkg::DivSteps + 1;

    logic               adv;
    cia_pkg::ctl_t      ctl_next;
    logic [63:0]        mag_a_next;
    logic [63:0]        mag_b_next;
    cia_pkg::ctl_t      ctl_reg [Depth];
    logic [Depth-1:0]   vld_reg;
    logic [63:0]        mag_a_reg;
    logic [63:0]        mag_b_reg;
    logic [127:0]       prod;
    logic [127:0]       prod_reg [Depth-4];
    logic [63:0]        quo;
    logic [63:0]        rem;
    cia_pkg::ctl_t      fin;
    logic [63:0]        lim;
    cia_pkg::out_item_t out_next;
    cia_pkg::out_item_t out_reg;
    logic               out_vld_reg;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    cia_front u_front (
        .in_item (s_data),
        .ctl     (ctl_next),
        .mag_a   (mag_a_next),
        .mag_b   (mag_b_next)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0] <= ctl_next;
            mag_a_reg  <= mag_a_next;
            mag_b_reg  <= mag_b_next;
            for (int i = 1; i < Depth; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Depth-2:0], s_valid};
        end
    end

    cia_mul u_mul (
        .aclk  (aclk),
        .en    (adv),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .prod  (prod)
    );

    cia_div u_div (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (mag_a_reg),
        .divisor   (mag_b_reg),
        .quotient  (quo),
        .remainder (rem)
    );

    // The product lines up with the fourth control stage; a delay line carries it to the end.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= prod;
            for (int i = 1; i < Depth - 4; i++) prod_reg[i] <= prod_reg[i-1];
        end
    end

    always_comb begin
        fin = ctl_reg[Depth-1];
        lim = fin.neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (fin.is_mul) begin
            if (prod_reg[Depth-5][127:64] != 64'd0 || prod_reg[Depth-5][63:0] > lim) begin
                fin.ovf = 1'b1;
            end else begin
                fin.valid = 1'b1;
                fin.val   = fin.neg_q ? (64'd0 - prod_reg[Depth-5][63:0])
                                      : prod_reg[Depth-5][63:0];
            end
        end else if (fin.is_div) begin
            fin.valid = 1'b1;
            fin.val   = fin.neg_q ? (64'd0 - quo) : quo;
        end else if (fin.is_mod) begin
            fin.valid = 1'b1;
            fin.val   = fin.neg_r ? (64'd0 - rem) : rem;
        end
        if (fin.valid && !fin.isbool && fin.rv &&
            (cia_pkg::slt(fin.val, fin.rmin) || cia_pkg::slt(fin.rmax, fin.val))) begin
            fin.valid = 1'b0;
            fin.ovf   = 1'b1;
        end
        out_next.result_valid   = fin.valid;
        out_next.overflow       = fin.ovf;
        out_next.result_is_bool = fin.valid & fin.isbool;
        out_next.result_value   = fin.valid ? fin.val : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (adv) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[Depth-1];
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/cia_front.sv =====
// Front stage of the checked integer ALU: opcode decode, simple results, operand magnitudes.
// Depends on cia_pkg.
module cia_front (
    input  cia_pkg::in_item_t in_item,
    output cia_pkg::ctl_t     ctl,
    output logic [63:0]       mag_a,
    output logic [63:0]       mag_b
);
    logic        unary;
    logic        match;
    logic        aint;
    logic        na;
    logic        nb;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;

    always_comb begin
        a     = in_item.operand_a;
        b     = in_item.operand_b;
        na    = a[63];
        nb    = b[63];
        mag_a = na ? (64'd0 - a) : a;
        mag_b = nb ? (64'd0 - b) : b;
        aint  = !in_item.a_is_bool;
        unary = in_item.command inside {cia_pkg::CMD_NEG, cia_pkg::CMD_POS, cia_pkg::CMD_NOT};
        match = unary || (in_item.a_is_bool == in_item.b_is_bool);
        r     = '0;
        ctl        = '0;
        ctl.neg_q  = na ^ nb;
        ctl.neg_r  = na;
        ctl.rv     = in_item.range_valid;
        ctl.rmin   = in_item.range_min;
        ctl.rmax   = in_item.range_max;
        if (match) begin
            case (in_item.command)
                cia_pkg::CMD_ADD: begin
                    if (aint) begin
                        r = a + b;
                        if (((a ^ r) & (b ^ r)) >> 63 != 64'd0) ctl.ovf = 1'b1;
                        else begin
                            ctl.valid = 1'b1;
                            ctl.val   = r;
                        end
                    end
                end
                cia_pkg::CMD_SUB: begin
                    if (aint) begin
                        r = a - b;
                        if (((a ^ b) & (a ^ r)) >> 63 != 64'd0) ctl.ovf = 1'b1;
                        else begin
                            ctl.valid = 1'b1;
                            ctl.val   = r;
                        end
                    end
                end
                cia_pkg::CMD_MUL: ctl.is_mul = aint;
                cia_pkg::CMD_DIV, cia_pkg::CMD_MOD: begin
                    if (aint && b != 64'd0) begin
                        if (b == '1 && (a == 64'h8000_0000_0000_0000 ||
                                        (in_item.range_valid && a == in_item.range_min))) begin
                            ctl.ovf = 1'b1;
                        end else begin
                            ctl.is_div = (in_item.command == cia_pkg::CMD_DIV);
                            ctl.is_mod = (in_item.command == cia_pkg::CMD_MOD);
                        end
                    end
                end
                cia_pkg::CMD_GT: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, cia_pkg::slt(b, a)};
                end
                cia_pkg::CMD_LT: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, cia_pkg::slt(a, b)};
                end
                cia_pkg::CMD_GE: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, !cia_pkg::slt(a, b)};
                end
                cia_pkg::CMD_LE: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, !cia_pkg::slt(b, a)};
                end
                cia_pkg::CMD_EQ: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, a == b};
                end
                cia_pkg::CMD_NE: begin
                    ctl.valid = aint; ctl.isbool = aint; ctl.val = {63'd0, a != b};
                end
                cia_pkg::CMD_NEG: begin
                    if (aint) begin
                        if (a == 64'h8000_0000_0000_0000) ctl.ovf = 1'b1;
                        else begin
                            ctl.valid = 1'b1;
                            ctl.val   = 64'd0 - a;
                        end
                    end
                end
                cia_pkg::CMD_POS: begin
                    ctl.valid = aint; ctl.val = a;
                end
                cia_pkg::CMD_AND: begin
                    ctl.valid = !aint; ctl.isbool = !aint; ctl.val = {63'd0, a[0] & b[0]};
                end
                cia_pkg::CMD_OR: begin
                    ctl.valid = !aint; ctl.isbool = !aint; ctl.val = {63'd0, a[0] | b[0]};
                end
                cia_pkg::CMD_BOOLEQ: begin
                    ctl.valid = !aint; ctl.isbool = !aint; ctl.val = {63'd0, ~(a[0] ^ b[0])};
                end
                cia_pkg::CMD_BOOLNE: begin
                    ctl.valid = !aint; ctl.isbool = !aint; ctl.val = {63'd0, a[0] ^ b[0]};
                end
                cia_pkg::CMD_NOT: begin
                    ctl.valid = !aint; ctl.isbool = !aint; ctl.val = {63'd0, ~a[0]};
                end
                default: ctl.valid = 1'b0;
            endcase
        end
        if (!ctl.valid) ctl.val = '0;
    end

endmodule

// ===== hdl/cia_mul.sv =====
// Pipelined 64x64 magnitude multiplier built from 32x32 partial products over three stages.
// No package dependencies. Advances when en is high.
module cia_mul (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  mag_a,
    input  logic [63:0]  mag_b,
    output logic [127:0] prod
);
    logic [63:0]  pp_reg [4];
    logic [127:0] sum1_reg;
    logic [127:0] sum2_reg;
    logic [63:0]  hi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0] <= mag_a[31:0]  * mag_b[31:0];
            pp_reg[1] <= mag_a[63:32] * mag_b[31:0];
            pp_reg[2] <= mag_a[31:0]  * mag_b[63:32];
            pp_reg[3] <= mag_a[63:32] * mag_b[63:32];
            sum1_reg  <= {pp_reg[3], pp_reg[0]} + {32'd0, pp_reg[1], 32'd0};
            hi_reg    <= pp_reg[2];
            sum2_reg  <= sum1_reg + {32'd0, hi_reg, 32'd0};
        end
    end

    assign prod = sum2_reg;

endmodule

// ===== hdl/cia_div.sv =====
// Pipelined restoring divider for 64-bit magnitudes, one quotient bit per stage.
// Depends on cia_pkg. Advances when en is high.
module cia_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    logic [63:0] rem_reg [cia_pkg::DivSteps];
    logic [63:0] quo_reg [cia_pkg::DivSteps];
    logic [63:0] dvs_reg [cia_pkg::DivSteps];

    for (genvar i = 0; i < cia_pkg::DivSteps; i++) begin : g_step
        logic [63:0] rem_in;
        logic [63:0] quo_in;
        logic [63:0] dvs_in;
        logic [64:0] trial;
        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign dvs_in = divisor;
        end else begin : g_chain
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
        end
        assign trial = {rem_in, quo_in[63]} - {1'b0, dvs_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                dvs_reg[i] <= dvs_in;
                if (!trial[64]) begin
                    rem_reg[i] <= trial[63:0];
                    quo_reg[i] <= {quo_in[62:0], 1'b1};
                end else begin
                    rem_reg[i] <= {rem_in[62:0], quo_in[63]};
                    quo_reg[i] <= {quo_in[62:0], 1'b0};
                end
            end
        end
    end

    assign quotient  = quo_reg[cia_pkg::DivSteps-1];
    assign remainder = rem_reg[cia_pkg::DivSteps-1];

endmodule

// ===== hdl/cia_checker.sv =====
// Port-level checker for the checked integer ALU, bound to the top level.
// Depends on cia_pkg and checked_integer_alu.
module cia_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cia_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction dropped or changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output free");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.result_valid && m_data.overflow))
        else $error("result and overflow both set");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.result_valid |->
            m_data.result_value == 64'd0 && !m_data.result_is_bool)
        else $error("empty result carries a value");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/checked_integer_alu_tb.sv =====
// Testbench for the checked integer ALU: directed and random folds, predicted in the bench.
// Depends on cia_pkg and checked_integer_alu; results are checked against a queue in order.
`timescale 1ns / 1ps

module checked_integer_alu_tb;

    localparam logic [63:0] MinInt = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxInt = 64'h7fff_ffff_ffff_ffff;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cia_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cia_pkg::out_item_t m_data;

    cia_pkg::out_item_t expected_folds[$];
    int                 error_count = 0;
    bit                 calm = 1'b0;

    checked_integer_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic cia_pkg::out_item_t fold(input cia_pkg::in_item_t it);
        cia_pkg::out_item_t r;
        logic [63:0]        a, b, ma, mb, lim, sum;
        logic               unary, aint, na, nb;
        a = it.operand_a;
        b = it.operand_b;
        r = '0;
        unary = it.command inside {cia_pkg::CMD_NEG, cia_pkg::CMD_POS, cia_pkg::CMD_NOT};
        aint = !it.a_is_bool;
        na = a[63];
        nb = b[63];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        if (unary || it.a_is_bool == it.b_is_bool) begin
            case (it.command)
                cia_pkg::CMD_ADD, cia_pkg::CMD_SUB: if (aint) begin
                    sum = (it.command == cia_pkg::CMD_ADD) ? a + b : a - b;
                    if (it.command == cia_pkg::CMD_ADD ? ((a ^ sum) & (b ^ sum)) >> 63
                                                       : ((a ^ b) & (a ^ sum)) >> 63)
                        r.overflow = 1'b1;
                    else begin
                        r.result_valid = 1'b1;
                        r.result_value = sum;
                    end
                end
                cia_pkg::CMD_MUL: if (aint) begin
                    lim = (na != nb) ? MinInt : MaxInt;
                    if (ma != 64'd0 && mb > lim / ma) r.overflow = 1'b1;
                    else begin
                        r.result_valid = 1'b1;
                        r.result_value = a * b;
                    end
                end
                cia_pkg::CMD_DIV, cia_pkg::CMD_MOD: if (aint && b != 64'd0) begin
                    if (b == '1 && (a == MinInt || (it.range_valid && a == it.range_min)))
                        r.overflow = 1'b1;
                    else begin
                        r.result_valid = 1'b1;
                        if (it.command == cia_pkg::CMD_DIV)
                            r.result_value = (na != nb) ? -(ma / mb) : ma / mb;
                        else
                            r.result_value = na ? -(ma % mb) : ma % mb;
                    end
                end
                cia_pkg::CMD_GT, cia_pkg::CMD_LT, cia_pkg::CMD_GE, cia_pkg::CMD_LE,
                cia_pkg::CMD_EQ, cia_pkg::CMD_NE: if (aint) begin
                    r.result_valid = 1'b1;
                    r.result_is_bool = 1'b1;
                    case (it.command)
                        cia_pkg::CMD_GT: r.result_value = 64'($signed(b) < $signed(a));
                        cia_pkg::CMD_LT: r.result_value = 64'($signed(a) < $signed(b));
                        cia_pkg::CMD_GE: r.result_value = 64'(!($signed(a) < $signed(b)));
                        cia_pkg::CMD_LE: r.result_value = 64'(!($signed(b) < $signed(a)));
                        cia_pkg::CMD_EQ: r.result_value = 64'(a == b);
                        default: r.result_value = 64'(a != b);
                    endcase
                end
                cia_pkg::CMD_NEG: if (aint) begin
                    if (a == MinInt) r.overflow = 1'b1;
                    else begin
                        r.result_valid = 1'b1;
                        r.result_value = -a;
                    end
                end
                cia_pkg::CMD_POS: if (aint) begin
                    r.result_valid = 1'b1;
                    r.result_value = a;
                end
                cia_pkg::CMD_AND, cia_pkg::CMD_OR, cia_pkg::CMD_BOOLEQ, cia_pkg::CMD_BOOLNE,
                cia_pkg::CMD_NOT: if (!aint) begin
                    r.result_valid = 1'b1;
                    r.result_is_bool = 1'b1;
                    case (it.command)
                        cia_pkg::CMD_AND: r.result_value = 64'(a[0] & b[0]);
                        cia_pkg::CMD_OR: r.result_value = 64'(a[0] | b[0]);
                        cia_pkg::CMD_BOOLEQ: r.result_value = 64'(!(a[0] ^ b[0]));
                        cia_pkg::CMD_BOOLNE: r.result_value = 64'(a[0] ^ b[0]);
                        default: r.result_value = 64'(!a[0]);
                    endcase
                end
                default: ;
            endcase
        end
        if (r.result_valid && !r.result_is_bool && it.range_valid &&
            ($signed(r.result_value) < $signed(it.range_min) ||
             $signed(it.range_max) < $signed(r.result_value))) begin
            r.result_valid = 1'b0;
            r.overflow = 1'b1;
        end
        if (!r.result_valid) begin
            r.result_is_bool = 1'b0;
            r.result_value = '0;
        end
        return r;
    endfunction

    task automatic send_op(input cia_pkg::in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        expected_folds.push_back(fold(it));
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return MinInt;
            1: return MaxInt;
            2: return '1;
            3: return 64'(signed'($urandom_range(0, 20)) - 10);
            4: return {$urandom, $urandom};
            5: return 64'($signed($urandom));
            6: return {32'h0, $urandom} >> $urandom_range(0, 31);
            default: return 64'(signed'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic cia_pkg::in_item_t random_op();
        cia_pkg::in_item_t it;
        it.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                                 : 5'($urandom_range(0, 17));
        it.a_is_bool = it.command >= cia_pkg::CMD_AND;
        it.b_is_bool = it.a_is_bool;
        if ($urandom_range(0, 9) == 0) it.a_is_bool = 1'($urandom);
        if ($urandom_range(0, 9) == 0) it.b_is_bool = 1'($urandom);
        it.operand_a = pick_value();
        it.operand_b = pick_value();
        it.range_valid = $urandom_range(0, 2) == 0;
        it.range_min = ($urandom_range(0, 1) == 0) ? -64'sd1000 : pick_value();
        it.range_max = ($urandom_range(0, 1) == 0) ? 64'sd1000 : pick_value();
        if (it.range_valid && $urandom_range(0, 3) == 0) it.operand_a = it.range_min;
        return it;
    endfunction

    function automatic cia_pkg::in_item_t make_op(input cia_pkg::cmd_t c, input logic ab,
                                                  input logic bb,
                                                  input logic [63:0] a, input logic [63:0] b,
                                                  input logic rv, input logic [63:0] lo,
                                                  input logic [63:0] hi);
        cia_pkg::in_item_t it;
        it = '{command: c, a_is_bool: ab, b_is_bool: bb, operand_a: a, operand_b: b,
               range_valid: rv, range_min: lo, range_max: hi};
        return it;
    endfunction

    task automatic test_directed();
        cia_pkg::cmd_t c;
        c = c.first();
        do begin
            send_op(make_op(c, c >= cia_pkg::CMD_AND, c >= cia_pkg::CMD_AND, 64'd7, 64'd3,
                            1'b0, '0, '0));
            c = c.next();
        end while (c != c.first());
        send_op(make_op(cia_pkg::CMD_ADD, 1'b0, 1'b0, MaxInt, 64'd1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_SUB, 1'b0, 1'b0, MinInt, 64'd1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_MUL, 1'b0, 1'b0, MinInt, '1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_DIV, 1'b0, 1'b0, MinInt, '1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_MOD, 1'b0, 1'b0, -64'sd8, '1, 1'b1, -64'sd8, 64'd8));
        send_op(make_op(cia_pkg::CMD_DIV, 1'b0, 1'b0, 64'd5, '0, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_NEG, 1'b0, 1'b1, MinInt, '0, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_ADD, 1'b0, 1'b1, 64'd1, 64'd1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::cmd_t'(5'd31), 1'b0, 1'b0, 64'd1, 64'd1, 1'b0, '0, '0));
        send_op(make_op(cia_pkg::CMD_POS, 1'b0, 1'b0, 64'd1, '0, 1'b1, 64'd5, 64'd2));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_op(random_op());
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_folds.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 4) != 0);
        end
    end

    always @(posedge aclk) begin
        cia_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_folds.size() == 0) begin
                $error("unexpected transaction %h", m_data);
                error_count++;
            end else begin
                e = expected_folds.pop_front();
                if (m_data.result_valid !== e.result_valid) begin
                    $error("result_valid exp %0b got %0b", e.result_valid, m_data.result_valid);
                    error_count++;
                end
                if (m_data.overflow !== e.overflow) begin
                    $error("overflow exp %0b got %0b", e.overflow, m_data.overflow);
                    error_count++;
                end
                if (m_data.result_is_bool !== e.result_is_bool) begin
                    $error("result_is_bool exp %0b got %0b", e.result_is_bool,
                           m_data.result_is_bool);
                    error_count++;
                end
                if (m_data.result_value !== e.result_value) begin
                    $error("result_value exp %h got %h", e.result_value, m_data.result_value);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain();
        test_random(550);
        calm = 1'b1;
        test_random(200);
        drain();
        repeat (80) @(posedge aclk);
        if (error_count == 0 && expected_folds.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== checked_integer_alu.f =====
hdl/cia_pkg.sv
hdl/cia_front.sv
hdl/cia_mul.sv
hdl/cia_div.sv
hdl/checked_integer_alu.sv
hdl/cia_checker.sv
tb/checked_integer_alu_tb.sv
